### design/fmm_pkg.sv
// ----------------------------------------------------------------------------
// fmm_pkg : shared types, constants and float helpers for the matrix engine
// sizes, item and state types, size clamping, binary32 rounding and leading zero count
// ----------------------------------------------------------------------------
package fmm_pkg;

    localparam int MAX_M   = 16;
    localparam int MAX_K   = 16;
    localparam int MAX_N   = 16;
    localparam int A_DEPTH = MAX_M * MAX_K;
    localparam int B_DEPTH = MAX_K * MAX_N;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_RD_C = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_ROWS  = 2'd0,
        CFG_DEPTH = 2'd1,
        CFG_COLS  = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [4:0] m;
        logic [4:0] k;
        logic [4:0] n;
    } t_sizes;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  idx;
        logic [31:0] val;
        logic        err;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_INIT,
        ST_RD,
        ST_MUL,
        ST_MRND,
        ST_ADD,
        ST_ARND,
        ST_OUT
    } t_bstate;

    function automatic logic [4:0] clamp_size(input logic [4:0] v, input logic [4:0] maxv);
        logic [4:0] r;
        if (v == 5'd0) begin
            r = 5'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] lz;
        lz = 6'd63;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                lz = 6'(63 - i);
            end
        end
        return lz;
    endfunction

    // sig has its leading one at bit 63, e is the biased exponent of that one
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [10:0] e,
                                             input logic [63:0] sig);
        logic [5:0]  sh;
        logic [9:0]  base;
        logic [63:0] mask;
        logic [63:0] x;
        logic        st;
        logic        rup;
        logic [34:0] sum;
        logic [31:0] r;
        if (e < 11'sd1) begin
            if (e < -11'sd62) begin
                sh = 6'd63;
            end else begin
                sh = 6'(11'sd1 - e);
            end
            base = 10'd0;
        end else begin
            sh   = 6'd0;
            base = 10'(e - 11'sd1);
        end
        mask = (64'd1 << sh) - 64'd1;
        st   = |(sig & mask);
        x    = sig >> sh;
        rup  = x[39] & (st | (|x[38:0]) | x[40]);
        // hidden bit carries into the exponent field, covering subnormal and overflow
        sum  = 35'({base, 23'd0}) + 35'(x[63:40]) + 35'(rup);
        if (sum >= 35'h0_7F80_0000) begin
            r = {sgn, 31'h7F80_0000};
        end else begin
            r = {sgn, sum[30:0]};
        end
        return r;
    endfunction

endpackage

### design/float_matrix_multiply.sv
// ----------------------------------------------------------------------------
// float_matrix_multiply : single-precision matrix product engine
// stores A and B words and returns elements of C = A * B on request
// ----------------------------------------------------------------------------
// use: each transaction on s_axis carries a mode, a linear index and a word.
// mode 0 and 1 write one A or B word, mode 2 returns C(m,n) for index n*M+m,
// summing A(m,k)*B(k,n) in ascending k with rounding after every operation.
// every transaction gives exactly one transaction on m_axis: the value and
// a status bit that flags an index beyond the active size or a bad mode.
// the user must set sizes M, K and N through the register port only while the
// block is idle; the block itself does not enforce this. a C read runs the
// index split, the INIT and RD states that start the reads, and per k step a
// multiply, an add and their roundings through the one shared multiplier and
// adder. the next item follows when the previous one leaves the back end; a
// two entry queue in front lets up to two more be accepted meanwhile.
// reset clears the size registers to 16 and empties queue and output; the
// stores keep whatever they held and must be written before they are read.
// when m_axis_tready is low the result is held and the queue fills, after
// which s_axis_tready drops.
// ----------------------------------------------------------------------------
module float_matrix_multiply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // mode[1:0], element_index[9:2], element_value[41:10]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_value[31:0], status[32]
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    fmm_pkg::t_item  f_item;
    fmm_pkg::t_item  q_item;
    fmm_pkg::t_sizes sizes;

    fmm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (f_item),
        .o_sizes     (sizes)
    );

    fmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fmm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sizes   (sizes),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata)
    );

endmodule

### design/fmm_front.sv
// ----------------------------------------------------------------------------
// fmm_front : input side of the matrix engine
// holds the size registers, checks each item's index and queues it
// ----------------------------------------------------------------------------
module fmm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [4:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [47:0]          i_data,
    input  logic                 i_q_full,
    output logic                 o_push,
    output fmm_pkg::t_item       o_item,
    output fmm_pkg::t_sizes      o_sizes
);

    logic [4:0] r_rows;
    logic [4:0] r_depth;
    logic [4:0] r_cols;
    logic [4:0] m_act;
    logic [4:0] k_act;
    logic [4:0] n_act;
    logic [9:0] lim_a;
    logic [9:0] lim_b;
    logic [9:0] lim_c;
    logic [9:0] idx_w;
    fmm_pkg::t_mode mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= 5'(fmm_pkg::MAX_M);
            r_depth <= 5'(fmm_pkg::MAX_K);
            r_cols  <= 5'(fmm_pkg::MAX_N);
        end else if (i_cfg_we) begin
            case (fmm_pkg::t_cfg_index'(i_cfg_index))
                fmm_pkg::CFG_ROWS:  r_rows  <= i_cfg_data;
                fmm_pkg::CFG_DEPTH: r_depth <= i_cfg_data;
                fmm_pkg::CFG_COLS:  r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        m_act = fmm_pkg::clamp_size(r_rows, 5'(fmm_pkg::MAX_M));
        k_act = fmm_pkg::clamp_size(r_depth, 5'(fmm_pkg::MAX_K));
        n_act = fmm_pkg::clamp_size(r_cols, 5'(fmm_pkg::MAX_N));
        lim_a = 10'(m_act * k_act);
        lim_b = 10'(k_act * n_act);
        lim_c = 10'(m_act * n_act);
        mode  = fmm_pkg::t_mode'(i_data[1:0]);
        idx_w = {2'b00, i_data[9:2]};
        o_item.mode = mode;
        o_item.idx  = i_data[9:2];
        o_item.val  = i_data[41:10];
        case (mode)
            fmm_pkg::MODE_WR_A: o_item.err = (idx_w >= lim_a);
            fmm_pkg::MODE_WR_B: o_item.err = (idx_w >= lim_b);
            fmm_pkg::MODE_RD_C: o_item.err = (idx_w >= lim_c);
            default:            o_item.err = 1'b1;
        endcase
        o_sizes.m = m_act;
        o_sizes.k = k_act;
        o_sizes.n = n_act;
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

### design/fmm_queue.sv
// ----------------------------------------------------------------------------
// fmm_queue : two-entry queue of checked items between front and back
// ----------------------------------------------------------------------------
module fmm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fmm_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output fmm_pkg::t_item  o_item
);

    fmm_pkg::t_item r_slot [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];

endmodule

### design/fmm_back.sv
// ----------------------------------------------------------------------------
// fmm_back : store and compute side of the matrix engine
// owns both stores, the index split and the multiply then add sequence
// ----------------------------------------------------------------------------
module fmm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fmm_pkg::t_sizes i_sizes,
    input  logic            i_q_valid,
    input  fmm_pkg::t_item  i_q_item,
    output logic            o_q_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [39:0]     o_tdata
);

    logic [31:0] a_mem [fmm_pkg::A_DEPTH];
    logic [31:0] b_mem [fmm_pkg::B_DEPTH];

    fmm_pkg::t_bstate r_state;
    fmm_pkg::t_bstate n_state;

    logic [31:0] r_ad;
    logic [31:0] r_bd;
    logic [7:0]  r_aaddr;
    logic [7:0]  r_baddr;
    logic [7:0]  r_rem;
    logic [3:0]  r_quo;
    logic [1:0]  r_bit;
    logic [4:0]  r_k;
    logic [31:0] r_acc;
    logic [31:0] r_prod;
    logic        r_err;
    logic        r_rd;
    logic        r_ovalid;
    logic [31:0] r_ores;
    logic        r_ostat;

    logic [47:0]        r_mp;
    logic signed [10:0] r_me;
    logic               r_ms;
    logic               r_mspec;
    logic [31:0]        r_mspecv;

    logic [50:0]        r_as;
    logic signed [10:0] r_ae;
    logic               r_asgn;
    logic               r_azs;
    logic               r_aspec;
    logic [31:0]        r_aspecv;

    logic        pop;
    logic        div_last;
    logic        k_last;
    logic        out_free;
    logic [8:0]  div_cmp;
    logic        div_ge;

    // multiply front stage
    logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero, m_sgn;
    logic [23:0] ma_sig, mb_sig;
    logic [7:0]  ma_exp, mb_exp;
    logic        m_spec;
    logic [31:0] m_specv;

    // multiply round stage
    logic [63:0] mn_sig;
    logic [5:0]  mn_lz;
    logic [31:0] m_res;

    // add front stage
    logic        xa_nan, xb_nan, xa_inf, xb_inf;
    logic        a_big;
    logic [31:0] ax, ay;
    logic [23:0] ax_sig, ay_sig;
    logic [7:0]  ax_exp, ay_exp;
    logic [7:0]  a_d;
    logic [49:0] ay_long, ay_sh, ay_mask;
    logic        ay_st;
    logic [50:0] a_sum;
    logic        a_spec;
    logic [31:0] a_specv;

    // add round stage
    logic [63:0] an_sig;
    logic [5:0]  an_lz;
    logic [31:0] a_res;
    logic [31:0] c_res;

    always_ff @(posedge i_clk) begin
        if (pop && !i_q_item.err && i_q_item.mode == fmm_pkg::MODE_WR_A) begin
            a_mem[i_q_item.idx] <= i_q_item.val;
        end
        r_ad <= a_mem[r_aaddr];
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_q_item.err && i_q_item.mode == fmm_pkg::MODE_WR_B) begin
            b_mem[i_q_item.idx] <= i_q_item.val;
        end
        r_bd <= b_mem[r_baddr];
    end

    always_comb begin
        div_cmp  = 9'(i_sizes.m) << r_bit;
        div_ge   = ({1'b0, r_rem} >= div_cmp);
        div_last = (r_bit == 2'd0);
        k_last   = (r_k == i_sizes.k - 5'd1);
        out_free = !r_ovalid || i_tready;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmm_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_item.err && i_q_item.mode == fmm_pkg::MODE_RD_C) begin
                        n_state = fmm_pkg::ST_DIV;
                    end else begin
                        n_state = fmm_pkg::ST_OUT;
                    end
                end
            end
            fmm_pkg::ST_DIV:  if (div_last) n_state = fmm_pkg::ST_INIT;
            fmm_pkg::ST_INIT: n_state = fmm_pkg::ST_RD;
            fmm_pkg::ST_RD:   n_state = fmm_pkg::ST_MUL;
            fmm_pkg::ST_MUL:  n_state = fmm_pkg::ST_MRND;
            fmm_pkg::ST_MRND: n_state = fmm_pkg::ST_ADD;
            fmm_pkg::ST_ADD:  n_state = fmm_pkg::ST_ARND;
            fmm_pkg::ST_ARND: n_state = k_last ? fmm_pkg::ST_OUT : fmm_pkg::ST_MUL;
            fmm_pkg::ST_OUT:  if (out_free) n_state = fmm_pkg::ST_IDLE;
            default:          n_state = fmm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop = (r_state == fmm_pkg::ST_IDLE) && i_q_valid;
    end

    assign o_q_pop = pop;

    // multiply, first half: specials and the raw significand product
    always_comb begin
        ma_exp  = r_ad[30:23];
        mb_exp  = r_bd[30:23];
        ma_nan  = (ma_exp == 8'hFF) && (r_ad[22:0] != 23'd0);
        mb_nan  = (mb_exp == 8'hFF) && (r_bd[22:0] != 23'd0);
        ma_inf  = (ma_exp == 8'hFF) && (r_ad[22:0] == 23'd0);
        mb_inf  = (mb_exp == 8'hFF) && (r_bd[22:0] == 23'd0);
        ma_zero = (ma_exp == 8'h00) && (r_ad[22:0] == 23'd0);
        mb_zero = (mb_exp == 8'h00) && (r_bd[22:0] == 23'd0);
        m_sgn   = r_ad[31] ^ r_bd[31];
        ma_sig  = {ma_exp != 8'h00, r_ad[22:0]};
        mb_sig  = {mb_exp != 8'h00, r_bd[22:0]};
        m_spec  = 1'b1;
        if (ma_nan || mb_nan || (ma_inf && mb_zero) || (ma_zero && mb_inf)) begin
            m_specv = fmm_pkg::QNAN;
        end else if (ma_inf || mb_inf) begin
            m_specv = {m_sgn, 31'h7F80_0000};
        end else if (ma_zero || mb_zero) begin
            m_specv = {m_sgn, 31'd0};
        end else begin
            m_specv = 32'd0;
            m_spec  = 1'b0;
        end
    end

    // multiply, second half: normalise and round
    always_comb begin
        mn_lz  = fmm_pkg::lzc64({r_mp, 16'd0});
        mn_sig = {r_mp, 16'd0} << mn_lz;
        if (r_mspec) begin
            m_res = r_mspecv;
        end else begin
            m_res = fmm_pkg::fp_round(r_ms, r_me - 11'(mn_lz), mn_sig);
        end
    end

    // add, first half: order by magnitude, align and add or subtract
    always_comb begin
        xa_nan = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] != 23'd0);
        xb_nan = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] != 23'd0);
        xa_inf = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] == 23'd0);
        xb_inf = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] == 23'd0);
        a_big  = (r_acc[30:0] >= r_prod[30:0]);
        ax     = a_big ? r_acc : r_prod;
        ay     = a_big ? r_prod : r_acc;
        ax_sig = {ax[30:23] != 8'h00, ax[22:0]};
        ay_sig = {ay[30:23] != 8'h00, ay[22:0]};
        ax_exp = (ax[30:23] == 8'h00) ? 8'd1 : ax[30:23];
        ay_exp = (ay[30:23] == 8'h00) ? 8'd1 : ay[30:23];
        a_d    = ax_exp - ay_exp;
        ay_long = {ay_sig, 26'd0};
        if (a_d >= 8'd50) begin
            ay_mask = 50'd0;
            ay_sh   = 50'd0;
            ay_st   = |ay_sig;
        end else begin
            ay_mask = (50'd1 << a_d) - 50'd1;
            ay_sh   = ay_long >> a_d;
            ay_st   = |(ay_long & ay_mask);
        end
        if (ax[31] == ay[31]) begin
            a_sum = {1'b0, ax_sig, 26'd0} + {1'b0, ay_sh | 50'(ay_st)};
        end else begin
            a_sum = {1'b0, ax_sig, 26'd0} - {1'b0, ay_sh | 50'(ay_st)};
        end
        a_spec = 1'b1;
        if (xa_nan || xb_nan || (xa_inf && xb_inf && (r_acc[31] != r_prod[31]))) begin
            a_specv = fmm_pkg::QNAN;
        end else if (xa_inf) begin
            a_specv = r_acc;
        end else if (xb_inf) begin
            a_specv = r_prod;
        end else begin
            a_specv = 32'd0;
            a_spec  = 1'b0;
        end
    end

    // add, second half: normalise and round into the accumulator
    always_comb begin
        an_lz  = fmm_pkg::lzc64({r_as, 13'd0});
        an_sig = {r_as, 13'd0} << an_lz;
        if (r_aspec) begin
            a_res = r_aspecv;
        end else if (r_as == 51'd0) begin
            // exact cancellation gives +0 unless both were negative zero
            a_res = {r_azs, 31'd0};
        end else begin
            a_res = fmm_pkg::fp_round(r_asgn, r_ae + 11'sd1 - 11'(an_lz), an_sig);
        end
        if ((r_acc[30:23] == 8'hFF) && (r_acc[22:0] != 23'd0)) begin
            c_res = fmm_pkg::QNAN;
        end else begin
            c_res = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fmm_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == fmm_pkg::ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            fmm_pkg::ST_IDLE: begin
                r_err <= i_q_item.err;
                r_rd  <= (i_q_item.mode == fmm_pkg::MODE_RD_C) && !i_q_item.err;
                r_rem <= i_q_item.idx;
                r_quo <= 4'd0;
                r_bit <= 2'd3;
            end
            fmm_pkg::ST_DIV: begin
                // one quotient bit per cycle: n = idx / M, m = idx % M
                if (div_ge) begin
                    r_rem        <= 8'({1'b0, r_rem} - div_cmp);
                    r_quo[r_bit] <= 1'b1;
                end
                r_bit <= r_bit - 2'd1;
            end
            fmm_pkg::ST_INIT: begin
                r_aaddr <= r_rem;
                r_baddr <= {4'd0, r_quo};
                r_k     <= 5'd0;
                r_acc   <= 32'd0;
            end
            fmm_pkg::ST_MUL: begin
                r_mp     <= ma_sig * mb_sig;
                r_me     <= 11'(ma_exp == 8'h00 ? 8'd1 : ma_exp)
                          + 11'(mb_exp == 8'h00 ? 8'd1 : mb_exp) - 11'sd126;
                r_ms     <= m_sgn;
                r_mspec  <= m_spec;
                r_mspecv <= m_specv;
                r_aaddr  <= r_aaddr + 8'(i_sizes.m);
                r_baddr  <= r_baddr + 8'(i_sizes.n);
            end
            fmm_pkg::ST_MRND: r_prod <= m_res;
            fmm_pkg::ST_ADD: begin
                r_as     <= a_sum;
                r_ae     <= 11'(ax_exp);
                r_asgn   <= ax[31];
                r_azs    <= r_acc[31] & r_prod[31];
                r_aspec  <= a_spec;
                r_aspecv <= a_specv;
            end
            fmm_pkg::ST_ARND: begin
                r_acc <= a_res;
                r_k   <= r_k + 5'd1;
            end
            fmm_pkg::ST_OUT: begin
                if (out_free) begin
                    r_ores  <= r_rd ? c_res : 32'd0;
                    r_ostat <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {7'd0, r_ostat, r_ores};

endmodule
